// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the serial report command decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SRCD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRCD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SRCD_ASSERT(lbl, clk, rst, prop, msg)
`define SRCD_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/core/srcd_pkg.sv =====
`timescale 1ns / 1ps
package srcd_pkg;

  localparam int FRAME_LIMIT_DEFAULT = 20;
  localparam int FRAME_DEPTH = 8;
  localparam int FRAME_IDX_W = $clog2(FRAME_DEPTH);
  localparam int ADDR_W = 14;
  localparam int DUMP_BYTES = 10;
  localparam int DATA_W = 8 * DUMP_BYTES;
  localparam int COUNT_W = $clog2(DUMP_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int WDATA_LSB = ADDR_W;

  localparam logic [7:0] FIRMWARE_VERSION_RESET = 8'h43;

  localparam logic [7:0] BYTE_READY          = 8'hA5;
  localparam logic [7:0] CMD_DUMP            = 8'h80;
  localparam logic [7:0] CMD_PING            = 8'h81;
  localparam logic [7:0] CMD_NVM_LOAD        = 8'h82;
  localparam logic [7:0] CMD_SCRIPT_START    = 8'h83;
  localparam logic [7:0] CMD_SCRIPT_STOP     = 8'h84;
  localparam logic [7:0] CMD_FW_QUERY        = 8'h85;
  localparam logic [7:0] REPLY_NAK           = 8'h00;
  localparam logic [7:0] REPLY_PONG          = 8'h80;
  localparam logic [7:0] REPLY_FLASH_START   = 8'h81;
  localparam logic [7:0] REPLY_FLASH_END     = 8'h82;
  localparam logic [7:0] REPLY_SCRIPT        = 8'h83;
  localparam logic [7:0] REPLY_SCRIPT_ACTIVE = 8'hFE;
  localparam logic [7:0] REPLY_REPORT        = 8'hFF;

  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_REPORT = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_START  = 3'd3,
    KIND_STOP   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_DUMP  = 2'd1,
    OP_SPLIT = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    kind_t              kind;
    logic [7:0]         tx;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data;
  } desc_t;

  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  hat;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } report_t;

  function automatic report_t unpack_report(input logic [63:0] frame);
    logic [31:0] f0, f1, f2, f3, f4, f5, f6, f7;
    report_t r;
    f0 = {24'b0, frame[7:0]};
    f1 = {24'b0, frame[15:8]};
    f2 = {24'b0, frame[23:16]};
    f3 = {24'b0, frame[31:24]};
    f4 = {24'b0, frame[39:32]};
    f5 = {24'b0, frame[47:40]};
    f6 = {24'b0, frame[55:48]};
    f7 = {24'b0, frame[63:56]};
    r.buttons = 16'((f0 << 9) | (f1 << 2) | (f2 >> 5));
    r.hat     = 8'((f2 << 3) | (f3 >> 4));
    r.left_x  = 8'((f3 << 4) | (f4 >> 3));
    r.left_y  = 8'((f4 << 5) | (f5 >> 2));
    r.right_x = 8'((f5 << 6) | (f6 >> 1));
    r.right_y = 8'((f6 << 7) | (f7 & 32'h7F));
    return r;
  endfunction

endpackage

// ===== rtl/core/serial_report_command_decoder.sv =====
// Serial report and command decoder.
// Input channel (in_valid/in_ready): one received serial byte per transfer, with the
// script engine status and debug values sampled alongside it.
// Output channel (out_valid/out_ready): one result per transfer; kind selects which
// payload fields carry meaning, and last marks the final result of an input byte.
// Configuration: cfg_write_enable writes cfg_write_data into the firmware version byte.
// A byte is classified when it is accepted, and its work, if it gives any result, is
// queued; the first result passes through the queue and then the output register.
// Results then follow one per cycle while the receiver takes them, up to ten for a
// debug dump. A two-entry queue between classification and result generation lets the
// input take one byte per cycle until the queue fills; bytes that give no result
// still need a free queue slot to be taken.
// When the receiver stalls, the output register holds its result and the queue
// fills, then in_ready drops.
// Reset clears the frame count, command arm, flash session, queue and output valid,
// and sets the firmware version to 0x43. Frame bytes are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serial_report_command_decoder import srcd_pkg::*; #(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic [7:0]        cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              script_running,
  input  logic [31:0]       loop_value,
  input  logic [31:0]       elapsed_ms,
  input  logic [15:0]       program_counter,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        tx_byte,
  output logic [15:0]       buttons,
  output logic [7:0]        hat,
  output logic [7:0]        left_x,
  output logic [7:0]        left_y,
  output logic [7:0]        right_x,
  output logic [7:0]        right_y,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_data,
  output logic              last
);

  logic [7:0] firmware_version;
  logic       push_valid, push_ready, head_valid, pop;
  desc_t      push_desc, head_desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      firmware_version <= FIRMWARE_VERSION_RESET;
    end else if (cfg_write_enable) begin
      firmware_version <= cfg_write_data;
    end
  end

  srcd_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .script_running   (script_running),
    .loop_value       (loop_value),
    .elapsed_ms       (elapsed_ms),
    .program_counter  (program_counter),
    .firmware_version (firmware_version),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_desc        (push_desc)
  );

  srcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .head_valid (head_valid),
    .pop        (pop),
    .head_desc  (head_desc)
  );

  srcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_desc     (head_desc),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .buttons       (buttons),
    .hat           (hat),
    .left_x        (left_x),
    .left_y        (left_y),
    .right_x       (right_x),
    .right_y       (right_y),
    .write_address (write_address),
    .write_data    (write_data),
    .last          (last)
  );

  `SRCD_ASSERT_NEVER(a_split_head_not_last, clk, rst, out_valid && last && (kind == KIND_REPORT || kind == KIND_START || kind == KIND_STOP), "report or script event marked last")
  `SRCD_ASSERT(a_flash_end_follows, clk, rst, out_valid && out_ready && kind == KIND_WRITE && !last |=> out_valid && kind == KIND_SEND && tx_byte == REPLY_FLASH_END, "flash end reply missing after final write")
  `SRCD_ASSERT(a_report_reply_follows, clk, rst, out_valid && out_ready && kind == KIND_REPORT |=> out_valid && last && kind == KIND_SEND && tx_byte == REPLY_REPORT, "report acknowledge missing")

endmodule

// ===== rtl/core/srcd_front.sv =====
`timescale 1ns / 1ps
module srcd_front import srcd_pkg::*; #(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        script_running,
  input  logic [31:0] loop_value,
  input  logic [31:0] elapsed_ms,
  input  logic [15:0] program_counter,
  input  logic [7:0]  firmware_version,
  output logic        push_valid,
  input  logic        push_ready,
  output desc_t       push_desc
);

  localparam int LW = $clog2(FRAME_LIMIT + 1);

  logic [7:0]        frame [FRAME_DEPTH];
  logic [LW-1:0]     frame_length, frame_length_next, len_inc;
  logic              command_armed, command_armed_next;
  logic [ADDR_W-1:0] flash_address, flash_address_next;
  logic [ADDR_W-1:0] flash_position, flash_position_next;
  logic [ADDR_W-1:0] flash_total, flash_total_next;
  logic              flash_active, has_result, accept;
  logic [63:0]       frame_word;
  desc_t             desc;

  assign in_ready     = push_ready;
  assign accept       = in_valid && push_ready;
  assign flash_active = flash_position < flash_total;
  assign len_inc      = frame_length + LW'(1);
  assign push_valid   = in_valid && has_result;
  assign push_desc    = desc;

  always_comb begin
    for (int i = 0; i < FRAME_DEPTH - 1; i++) begin
      frame_word[8*i +: 8] = frame[i];
    end
    frame_word[63:56] = rx_byte;
  end

  always_comb begin
    desc                = '0;
    desc.op             = OP_SEND;
    desc.kind           = KIND_SEND;
    desc.count          = COUNT_W'(1);
    has_result          = 1'b0;
    frame_length_next   = frame_length;
    command_armed_next  = command_armed;
    flash_address_next  = flash_address;
    flash_position_next = flash_position;
    flash_total_next    = flash_total;
    if (flash_active) begin
      has_result = 1'b1;
      desc.op = OP_SPLIT;
      desc.kind = KIND_WRITE;
      desc.tx = REPLY_FLASH_END;
      desc.data[ADDR_W-1:0] = flash_address + flash_position;
      desc.data[WDATA_LSB +: 8] = rx_byte;
      flash_position_next = flash_position + ADDR_W'(1);
      desc.count = (flash_position_next == flash_total) ? COUNT_W'(2) : COUNT_W'(1);
    end else begin
      frame_length_next = (len_inc >= LW'(FRAME_LIMIT)) ? '0 : len_inc;
      if (rx_byte[7]) begin
        frame_length_next = '0;
        if (len_inc == LW'(1) && !command_armed && rx_byte == BYTE_READY) begin
          command_armed_next = 1'b1;
        end else if (len_inc == LW'(FRAME_DEPTH)) begin
          command_armed_next = 1'b0;
          has_result = 1'b1;
          if (script_running) begin
            desc.tx = REPLY_SCRIPT_ACTIVE;
          end else begin
            desc.op = OP_SPLIT;
            desc.kind = KIND_REPORT;
            desc.tx = REPLY_REPORT;
            desc.count = COUNT_W'(2);
            desc.data[63:0] = frame_word;
          end
        end else if (command_armed) begin
          command_armed_next = 1'b0;
          has_result = 1'b1;
          unique case (rx_byte)
            CMD_DUMP: begin
              desc.op = OP_DUMP;
              desc.count = COUNT_W'(DUMP_BYTES);
              desc.data = {program_counter, elapsed_ms, loop_value};
            end
            CMD_FW_QUERY: desc.tx = firmware_version;
            BYTE_READY: begin
              command_armed_next = 1'b1;
              has_result = 1'b0;
            end
            CMD_PING: desc.tx = REPLY_PONG;
            CMD_NVM_LOAD: begin
              if (len_inc != LW'(5)) begin
                desc.tx = REPLY_NAK;
              end else begin
                desc.op = OP_SPLIT;
                desc.kind = KIND_STOP;
                desc.tx = REPLY_FLASH_START;
                desc.count = COUNT_W'(2);
                flash_address_next = {frame[1][6:0], frame[0][6:0]};
                flash_total_next = {frame[3][6:0], frame[2][6:0]};
                flash_position_next = '0;
              end
            end
            CMD_SCRIPT_START: begin
              desc.op = OP_SPLIT;
              desc.kind = KIND_START;
              desc.tx = REPLY_SCRIPT;
              desc.count = COUNT_W'(2);
            end
            CMD_SCRIPT_STOP: begin
              desc.op = OP_SPLIT;
              desc.kind = KIND_STOP;
              desc.tx = REPLY_SCRIPT;
              desc.count = COUNT_W'(2);
            end
            default: desc.tx = REPLY_NAK;
          endcase
        end else begin
          has_result = 1'b1;
          desc.tx = 8'(len_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length   <= '0;
      command_armed  <= 1'b0;
      flash_address  <= '0;
      flash_position <= '0;
      flash_total    <= '0;
    end else if (accept) begin
      frame_length   <= frame_length_next;
      command_armed  <= command_armed_next;
      flash_address  <= flash_address_next;
      flash_position <= flash_position_next;
      flash_total    <= flash_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !flash_active && frame_length < LW'(FRAME_DEPTH)) begin
      frame[frame_length[FRAME_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/srcd_queue.sv =====
`timescale 1ns / 1ps
module srcd_queue import srcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  desc_t push_desc,
  output logic  head_valid,
  input  logic  pop,
  output desc_t head_desc
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  desc_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = count != CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_desc  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== rtl/core/srcd_back.sv =====
`timescale 1ns / 1ps
module srcd_back import srcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  desc_t             head_desc,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        tx_byte,
  output logic [15:0]       buttons,
  output logic [7:0]        hat,
  output logic [7:0]        left_x,
  output logic [7:0]        left_y,
  output logic [7:0]        right_x,
  output logic [7:0]        right_y,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_data,
  output logic              last
);

  logic [COUNT_W-1:0] idx;
  logic               load, item_last;
  kind_t              item_kind, kind_q;
  logic [7:0]         item_tx;
  report_t            item_report, report_q;
  logic [ADDR_W-1:0]  item_waddr;
  logic [7:0]         item_wdata;

  assign load      = head_valid && (!out_valid || out_ready);
  assign item_last = idx == head_desc.count - COUNT_W'(1);
  assign pop       = load && item_last;

  always_comb begin
    item_kind   = KIND_SEND;
    item_tx     = '0;
    item_report = '0;
    item_waddr  = '0;
    item_wdata  = '0;
    unique case (head_desc.op)
      OP_DUMP: item_tx = head_desc.data[{idx, 3'b000} +: 8];
      OP_SPLIT: begin
        if (idx == '0) begin
          item_kind = head_desc.kind;
          case (head_desc.kind)
            KIND_REPORT: item_report = unpack_report(head_desc.data[63:0]);
            KIND_WRITE: begin
              item_waddr = head_desc.data[ADDR_W-1:0];
              item_wdata = head_desc.data[WDATA_LSB +: 8];
            end
            default: ;
          endcase
        end else begin
          item_tx = head_desc.tx;
        end
      end
      default: item_tx = head_desc.tx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= item_last ? '0 : idx + COUNT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_q        <= item_kind;
      tx_byte       <= item_tx;
      report_q      <= item_report;
      write_address <= item_waddr;
      write_data    <= item_wdata;
      last          <= item_last;
    end
  end

  assign kind    = kind_q;
  assign buttons = report_q.buttons;
  assign hat     = report_q.hat;
  assign left_x  = report_q.left_x;
  assign left_y  = report_q.left_y;
  assign right_x = report_q.right_x;
  assign right_y = report_q.right_y;

endmodule

// ===== bench/decoder_checker.sv =====
`timescale 1ns / 1ps
module decoder_checker import srcd_pkg::*; #(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic [7:0]        cfg_write_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              script_running,
  input  logic [31:0]       loop_value,
  input  logic [31:0]       elapsed_ms,
  input  logic [15:0]       program_counter,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        kind,
  input  logic [7:0]        tx_byte,
  input  logic [15:0]       buttons,
  input  logic [7:0]        hat,
  input  logic [7:0]        left_x,
  input  logic [7:0]        left_y,
  input  logic [7:0]        right_x,
  input  logic [7:0]        right_y,
  input  logic [ADDR_W-1:0] write_address,
  input  logic [7:0]        write_data,
  input  logic              last,
  output int unsigned       mismatches,
  output int unsigned       results_outstanding,
  output int unsigned       results_seen,
  output int unsigned       reports_seen,
  output int unsigned       writes_seen
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        tx;
    logic [15:0]       buttons;
    logic [7:0]        hat;
    logic [7:0]        left_x;
    logic [7:0]        left_y;
    logic [7:0]        right_x;
    logic [7:0]        right_y;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              last;
  } result_t;

  logic [7:0]        frame_store [FRAME_DEPTH];
  int                frame_len;
  logic              armed;
  logic [ADDR_W-1:0] flash_base;
  logic [ADDR_W-1:0] flash_pos;
  logic [ADDR_W-1:0] flash_len;
  logic [7:0]        version;

  result_t     expected_results[$];
  result_t     step_results[$];
  int unsigned fail_count;
  int unsigned seen_count;
  int unsigned report_count;
  int unsigned write_count;

  initial begin
    fail_count   = 0;
    seen_count   = 0;
    report_count = 0;
    write_count  = 0;
  end

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t decoder_checker: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic result_t blank_result(kind_t k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic push_send(logic [7:0] b);
    result_t r;
    r = blank_result(KIND_SEND);
    r.tx = b;
    step_results.push_back(r);
  endtask

  task automatic push_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) begin
      push_send(v[8*i +: 8]);
    end
  endtask

  task automatic run_command(logic [7:0] b, logic [31:0] loop_v, logic [31:0] elapsed_v,
                             logic [15:0] pc_v);
    armed = 1'b0;
    case (b)
      CMD_DUMP: begin
        push_le(loop_v, 4);
        push_le(elapsed_v, 4);
        push_le({16'h0, pc_v}, 2);
      end
      CMD_FW_QUERY: push_send(version);
      BYTE_READY: armed = 1'b1;
      CMD_PING: push_send(REPLY_PONG);
      CMD_NVM_LOAD: begin
        if (frame_len != 5) begin
          push_send(REPLY_NAK);
        end else begin
          step_results.push_back(blank_result(KIND_STOP));
          flash_base = {frame_store[1][6:0], frame_store[0][6:0]};
          flash_len  = {frame_store[3][6:0], frame_store[2][6:0]};
          flash_pos  = '0;
          push_send(REPLY_FLASH_START);
        end
      end
      CMD_SCRIPT_START: begin
        step_results.push_back(blank_result(KIND_START));
        push_send(REPLY_SCRIPT);
      end
      CMD_SCRIPT_STOP: begin
        step_results.push_back(blank_result(KIND_STOP));
        push_send(REPLY_SCRIPT);
      end
      default: push_send(REPLY_NAK);
    endcase
  endtask

  task automatic decode_byte(logic [7:0] b, logic running, logic [31:0] loop_v,
                             logic [31:0] elapsed_v, logic [15:0] pc_v);
    result_t     r;
    logic [31:0] fb [FRAME_DEPTH];
    logic [31:0] bits;
    logic [7:0]  len_byte;
    step_results.delete();
    if (flash_pos < flash_len) begin
      r = blank_result(KIND_WRITE);
      r.waddr = flash_base + flash_pos;
      r.wdata = b;
      step_results.push_back(r);
      flash_pos++;
      if (flash_pos == flash_len) push_send(REPLY_FLASH_END);
    end else begin
      if (frame_len < FRAME_DEPTH) frame_store[frame_len] = b;
      frame_len++;
      if (b[7]) begin
        if (frame_len == 1 && !armed && b == BYTE_READY) begin
          armed = 1'b1;
        end else if (frame_len == FRAME_DEPTH) begin
          if (running) begin
            push_send(REPLY_SCRIPT_ACTIVE);
          end else begin
            for (int i = 0; i < FRAME_DEPTH; i++) fb[i] = {24'h0, frame_store[i]};
            r = blank_result(KIND_REPORT);
            bits = (fb[0] << 9) | (fb[1] << 2) | (fb[2] >> 5);
            r.buttons = bits[15:0];
            bits = (fb[2] << 3) | (fb[3] >> 4);
            r.hat = bits[7:0];
            bits = (fb[3] << 4) | (fb[4] >> 3);
            r.left_x = bits[7:0];
            bits = (fb[4] << 5) | (fb[5] >> 2);
            r.left_y = bits[7:0];
            bits = (fb[5] << 6) | (fb[6] >> 1);
            r.right_x = bits[7:0];
            bits = (fb[6] << 7) | (fb[7] & 32'h7F);
            r.right_y = bits[7:0];
            step_results.push_back(r);
            push_send(REPLY_REPORT);
          end
          armed = 1'b0;
        end else if (armed) begin
          run_command(b, loop_v, elapsed_v, pc_v);
        end else begin
          len_byte = frame_len[7:0];
          push_send(len_byte);
        end
        frame_len = 0;
      end
      if (frame_len >= FRAME_LIMIT) frame_len = 0;
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    while (step_results.size() > 0) expected_results.push_back(step_results.pop_front());
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s is %0h, expected %0h",
                                seen_count, name, got, want));
    end
  endtask

  task automatic check_result();
    result_t want;
    seen_count++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d (kind %0d, tx %02h) with nothing expected",
                                seen_count, kind, tx_byte));
    end else begin
      want = expected_results.pop_front();
      if (want.kind == KIND_REPORT) report_count++;
      if (want.kind == KIND_WRITE) write_count++;
      compare_field("kind", 32'(kind), 32'(want.kind));
      compare_field("tx_byte", 32'(tx_byte), 32'(want.tx));
      compare_field("buttons", 32'(buttons), 32'(want.buttons));
      compare_field("hat", 32'(hat), 32'(want.hat));
      compare_field("left_x", 32'(left_x), 32'(want.left_x));
      compare_field("left_y", 32'(left_y), 32'(want.left_y));
      compare_field("right_x", 32'(right_x), 32'(want.right_x));
      compare_field("right_y", 32'(right_y), 32'(want.right_y));
      compare_field("write_address", 32'(write_address), 32'(want.waddr));
      compare_field("write_data", 32'(write_data), 32'(want.wdata));
      compare_field("last", 32'(last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_len  = 0;
      armed      = 1'b0;
      flash_base = '0;
      flash_pos  = '0;
      flash_len  = '0;
      version    = FIRMWARE_VERSION_RESET;
      expected_results.delete();
    end else begin
      if (cfg_write_enable) version = cfg_write_data;
      if (in_valid && in_ready) begin
        decode_byte(rx_byte, script_running, loop_value, elapsed_ms, program_counter);
      end
      if (out_valid && out_ready) check_result();
    end
    mismatches          <= fail_count;
    results_outstanding <= expected_results.size();
    results_seen        <= seen_count;
    reports_seen        <= report_count;
    writes_seen         <= write_count;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import srcd_pkg::*; ();

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PHASE_ITEMS     = 100;

  typedef struct packed {
    logic [7:0]  rx;
    logic        running;
    logic [31:0] loop_v;
    logic [31:0] elapsed_v;
    logic [15:0] pc_v;
  } rx_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_enable = 1'b0;
  logic [7:0]        cfg_write_data = 8'h0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte = 8'h0;
  logic              script_running = 1'b0;
  logic [31:0]       loop_value = 32'h0;
  logic [31:0]       elapsed_ms = 32'h0;
  logic [15:0]       program_counter = 16'h0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        tx_byte;
  logic [15:0]       buttons;
  logic [7:0]        hat;
  logic [7:0]        left_x;
  logic [7:0]        left_y;
  logic [7:0]        right_x;
  logic [7:0]        right_y;
  logic [ADDR_W-1:0] write_address;
  logic [7:0]        write_data;
  logic              last;

  int unsigned mismatches;
  int unsigned results_outstanding;
  int unsigned results_seen;
  int unsigned reports_seen;
  int unsigned writes_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  rx_item_t    byte_plan[$];

  serial_report_command_decoder dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .script_running   (script_running),
    .loop_value       (loop_value),
    .elapsed_ms       (elapsed_ms),
    .program_counter  (program_counter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .tx_byte          (tx_byte),
    .buttons          (buttons),
    .hat              (hat),
    .left_x           (left_x),
    .left_y           (left_y),
    .right_x          (right_x),
    .right_y          (right_y),
    .write_address    (write_address),
    .write_data       (write_data),
    .last             (last)
  );

  decoder_checker decode_check (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_write_data      (cfg_write_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .rx_byte             (rx_byte),
    .script_running      (script_running),
    .loop_value          (loop_value),
    .elapsed_ms          (elapsed_ms),
    .program_counter     (program_counter),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .kind                (kind),
    .tx_byte             (tx_byte),
    .buttons             (buttons),
    .hat                 (hat),
    .left_x              (left_x),
    .left_y              (left_y),
    .right_x             (right_x),
    .right_y             (right_y),
    .write_address       (write_address),
    .write_data          (write_data),
    .last                (last),
    .mismatches          (mismatches),
    .results_outstanding (results_outstanding),
    .results_seen        (results_seen),
    .reports_seen        (reports_seen),
    .writes_seen         (writes_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hold off the receiver for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen  = hold_requests;
      stall_left = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic plan_full(logic [7:0] b, logic running, logic [31:0] loop_v,
                           logic [31:0] elapsed_v, logic [15:0] pc_v);
    rx_item_t it;
    it.rx        = b;
    it.running   = running;
    it.loop_v    = loop_v;
    it.elapsed_v = elapsed_v;
    it.pc_v      = pc_v;
    byte_plan.push_back(it);
  endtask

  task automatic plan_byte(logic [7:0] b);
    plan_full(b, 1'($urandom_range(1)), $urandom, $urandom, 16'($urandom_range(65535)));
  endtask

  task automatic plan_command(logic [7:0] cmd);
    plan_byte(BYTE_READY);
    plan_byte(cmd);
  endtask

  task automatic plan_report(logic running);
    for (int i = 0; i < FRAME_DEPTH - 1; i++) begin
      plan_full(8'($urandom_range(127)), running, $urandom, $urandom,
                16'($urandom_range(65535)));
    end
    plan_full(8'($urandom_range(128, 255)), running, $urandom, $urandom,
              16'($urandom_range(65535)));
  endtask

  task automatic plan_flash(logic [13:0] base, logic [13:0] count);
    plan_byte(BYTE_READY);
    plan_byte({1'b0, base[6:0]});
    plan_byte({1'b0, base[13:7]});
    plan_byte({1'b0, count[6:0]});
    plan_byte({1'b0, count[13:7]});
    plan_byte(CMD_NVM_LOAD);
    repeat (count) plan_byte(8'($urandom_range(255)));
  endtask

  // mostly well-formed frames and commands, the rest noise and broken sequences
  task automatic plan_random_traffic(int target);
    int unsigned pick;
    logic [13:0] base;
    logic [13:0] count;
    while (byte_plan.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        plan_report($urandom_range(3) == 0);
      end else if (pick < 62) begin
        case ($urandom_range(7))
          0: plan_command(CMD_DUMP);
          1: plan_command(CMD_PING);
          2: plan_command(CMD_NVM_LOAD);
          3: plan_command(CMD_SCRIPT_START);
          4: plan_command(CMD_SCRIPT_STOP);
          5: plan_command(CMD_FW_QUERY);
          6: plan_command(BYTE_READY);
          default: plan_command(8'($urandom_range(8'h86, 8'hFF)));
        endcase
      end else if (pick < 72) begin
        base  = ($urandom_range(3) == 0) ? 14'(32'h3FFF - $urandom_range(3))
                                         : 14'($urandom_range(16383));
        count = ($urandom_range(9) == 0) ? 14'($urandom_range(20, 40))
                                         : 14'($urandom_range(6));
        plan_flash(base, count);
      end else if (pick < 86) begin
        repeat ($urandom_range(24)) plan_byte(8'($urandom_range(127)));
        plan_byte(8'($urandom_range(128, 255)));
      end else begin
        case ($urandom_range(3))
          0: begin
            plan_byte(BYTE_READY);
            repeat ($urandom_range(1, 6)) plan_byte(8'($urandom_range(127)));
            plan_byte(CMD_NVM_LOAD);
          end
          1: begin
            plan_byte(BYTE_READY);
            plan_report(1'($urandom_range(1)));
          end
          2: plan_byte(BYTE_READY);
          default: plan_byte(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  task automatic send_item(rx_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    rx_byte         <= it.rx;
    script_running  <= it.running;
    loop_value      <= it.loop_v;
    elapsed_ms      <= it.elapsed_v;
    program_counter <= it.pc_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_plan();
    while (byte_plan.size() > 0) send_item(byte_plan.pop_front());
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(logic [7:0] v);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic run_phase(int items);
    // close any open frame, then read back the version
    plan_byte(8'h90);
    plan_command(CMD_FW_QUERY);
    plan_random_traffic(items / 3);
    send_plan();
    hold_requests <= hold_requests + 1;
    plan_random_traffic(items / 3);
    send_plan();
    wait_for_results();
    plan_random_traffic(items / 3);
    send_plan();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct <= 80;

    plan_command(CMD_FW_QUERY);
    plan_byte(BYTE_READY);
    plan_byte(BYTE_READY);
    plan_full(CMD_DUMP, 1'b1, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
    plan_command(CMD_NVM_LOAD);
    plan_flash(14'h0, 14'h0);
    repeat (FRAME_DEPTH - 1) plan_full(8'h7F, 1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0);
    plan_full(8'hFF, 1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0);
    plan_byte(8'h90);
    plan_command(8'h86);
    send_plan();
    settle();

    write_version(8'h00);
    run_phase(PHASE_ITEMS);

    send_idle_pct = 80;
    recv_idle_pct <= 23;
    write_version(8'hFF);
    run_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_version(8'($urandom_range(1, 254)));
    run_phase(PHASE_ITEMS);

    $display("Covered %0d input bytes under three idle profiles and long output hold-offs,",
             bytes_sent);
    $display("checking %0d results: %0d controller reports, %0d memory writes, %0d mismatches",
             results_seen, reports_seen, writes_seen, mismatches);
    if (mismatches == 0 && results_outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
